@@ hdl/atan2_rational_approximation_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the atan2 rational approximation core
// Clocked assertion helpers used by the core to check its own logic.
// ----------------------------------------------------------------------------
`ifndef ATAN2_RATIONAL_APPROXIMATION_CORE_DEFINES_SVH
`define ATAN2_RATIONAL_APPROXIMATION_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define A2R_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("atan2 core assertion failed");
// Check a property on every clock edge, reset included.
`define A2R_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("atan2 core assertion failed");
`else
`define A2R_ASSERT(label, prop)
`define A2R_ASSERT_ALWAYS(label, prop)
`endif
`endif

@@ hdl/a2r_pkg.sv @@
// ----------------------------------------------------------------------------
// a2r_pkg
// Types, Q30 constants and the ratio multiply used by the atan2 pipeline.
// ----------------------------------------------------------------------------
package a2r_pkg;

  // Ratio width (unsigned Q16, up to 1.0 inclusive).
  localparam int RATIO_W = 17;
  // Width of the signed Horner values.
  localparam int VAL_W   = 34;
  // Quotient width of the final division.
  localparam int QUOT_W  = 31;
  localparam int ANGLE_W = 16;

  typedef logic signed [VAL_W-1:0] val_t;

  // Side flags that travel with each item.
  typedef struct packed {
    logic hzero;
    logic swap;
    logic yneg;
    logic xneg;
  } side_t;

  localparam val_t COEF_A      = 34'sd54011108;
  localparam val_t COEF_B      = 34'sd332840025;
  localparam val_t COEF_C      = 34'sd158312570;
  localparam val_t COEF_D      = 34'sd1073713441;
  localparam val_t COEF_E      = 34'sd338;
  localparam val_t COEF_F      = 34'sd691988024;
  localparam val_t COEF_G      = 34'sd157951624;
  localparam val_t ONE_Q30     = 34'sd1073741824;
  localparam val_t PI_Q30      = 34'sd3373259426;
  localparam val_t HALF_PI_Q30 = 34'sd1686629713;
  localparam int   PI_Q13      = 25736;

  // Multiply a Q30 value by the Q16 ratio, rounding ties away from zero.
  function automatic val_t mul_ratio(input val_t v, input logic [RATIO_W-1:0] r);
    logic                       neg;
    logic [VAL_W-1:0]           mag;
    logic [VAL_W+RATIO_W-1:0]   prod;
    logic [VAL_W-1:0]           res;
    neg  = v[VAL_W-1];
    mag  = neg ? VAL_W'(-v) : VAL_W'(v);
    prod = ((VAL_W+RATIO_W)'(mag) * (VAL_W+RATIO_W)'(r))
           + (VAL_W+RATIO_W)'(32768);
    res  = prod[VAL_W+15:16];
    return neg ? val_t'(-res) : val_t'(res);
  endfunction

endpackage

@@ hdl/a2r_div_cell.sv @@
// ----------------------------------------------------------------------------
// a2r_div_cell
// One restoring division step: shifts in a dividend bit, subtracts the
// divisor when it fits and shifts the quotient bit into the same register.
// ----------------------------------------------------------------------------
module a2r_div_cell #(
  parameter int DW = 16,
  parameter int NB = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [DW-1:0]       in_div,
  input  logic [DW-1:0]       in_rem,
  input  logic [NB-1:0]       in_bits,
  input  a2r_pkg::side_t      in_side,
  output logic                out_valid,
  output logic [DW-1:0]       out_div,
  output logic [DW-1:0]       out_rem,
  output logic [NB-1:0]       out_bits,
  output a2r_pkg::side_t      out_side
);
  import a2r_pkg::*;

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial = {in_rem, in_bits[NB-1]};
    diff  = trial - {1'b0, in_div};
    fits  = trial >= {1'b0, in_div};
  end

  // Valid bit of this cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // Payload handed to the next cell.
  always_ff @(posedge clk) begin
    if (en) begin
      out_div  <= in_div;
      out_rem  <= fits ? diff[DW-1:0] : trial[DW-1:0];
      out_bits <= {in_bits[NB-2:0], fits};
      out_side <= in_side;
    end
  end

endmodule

@@ hdl/a2r_horner_cell.sv @@
// ----------------------------------------------------------------------------
// a2r_horner_cell
// One Horner step of the numerator and, where enabled, of the denominator.
// ----------------------------------------------------------------------------
module a2r_horner_cell #(
  parameter logic signed [33:0] KN     = 34'sd0,
  parameter logic signed [33:0] KD     = 34'sd0,
  parameter bit                 DEN_EN = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [a2r_pkg::RATIO_W-1:0]   in_ratio,
  input  a2r_pkg::val_t                 in_num,
  input  a2r_pkg::val_t                 in_den,
  input  a2r_pkg::side_t                in_side,
  output logic                          out_valid,
  output logic [a2r_pkg::RATIO_W-1:0]   out_ratio,
  output a2r_pkg::val_t                 out_num,
  output a2r_pkg::val_t                 out_den,
  output a2r_pkg::side_t                out_side
);
  import a2r_pkg::*;

  val_t num_next;
  val_t den_next;

  // Multiply by the ratio and add this step's coefficient.
  always_comb begin
    num_next = mul_ratio(in_num, in_ratio) + KN;
    den_next = DEN_EN ? (mul_ratio(in_den, in_ratio) + KD) : in_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ratio <= in_ratio;
      out_num   <= num_next;
      out_den   <= den_next;
      out_side  <= in_side;
    end
  end

endmodule

@@ hdl/atan2_rational_approximation_core.sv @@
// ----------------------------------------------------------------------------
// atan2_rational_approximation_core
// Four-quadrant arctangent by a ratio divider, a rational polynomial and a
// quotient divider, all built as a chain of registered cells.
// ----------------------------------------------------------------------------
// Stages from input item to result item: 1 prepare, 17 ratio division
// cells, 4 Horner cells, 1 quotient prepare, 31 quotient division cells,
// 1 fold and output register. Throughput: one item per cycle while the
// chain advances; it advances while the output register is empty or taken.
// Reset clears every valid bit; no item is in flight after reset.
module atan2_rational_approximation_core #(
  parameter int COMPONENT_WIDTH = 16
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // Fields from bit 0 up: x_comp, y_comp, zero fill.
  input  logic [((2*COMPONENT_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // Fields from bit 0 up: angle.
  output logic [15:0]                              m_tdata
);
  import a2r_pkg::*;

  `include "atan2_rational_approximation_core_defines.svh"

  localparam int W      = COMPONENT_WIDTH;
  localparam int NDW    = W + 17;
  localparam int QDIV_W = 31;
  localparam int QDVD_W = 61;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input stage: magnitudes, ordering and ratio dividend.
  logic [W-1:0]   x_comp, y_comp, ax, ay, hi, lo;
  logic [NDW-1:0] rdvd;
  side_t          side0;
  always_comb begin
    x_comp      = s_tdata[W-1:0];
    y_comp      = s_tdata[2*W-1:W];
    ax          = x_comp[W-1] ? W'(-x_comp) : x_comp;
    ay          = y_comp[W-1] ? W'(-y_comp) : y_comp;
    side0.xneg  = x_comp[W-1];
    side0.yneg  = y_comp[W-1];
    side0.swap  = ay > ax;
    hi          = side0.swap ? ay : ax;
    lo          = side0.swap ? ax : ay;
    side0.hzero = hi == '0;
    rdvd        = {1'b0, lo, 16'd0} + NDW'(hi >> 1);
  end

  logic           rv   [0:RATIO_W];
  logic [W-1:0]   rdiv [0:RATIO_W];
  logic [W-1:0]   rrem [0:RATIO_W];
  logic [16:0]    rbits[0:RATIO_W];
  side_t          rside[0:RATIO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv[0] <= 1'b0;
    end else if (en) begin
      rv[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rdiv[0]  <= hi;
      rrem[0]  <= rdvd[NDW-1:17];
      rbits[0] <= rdvd[16:0];
      rside[0] <= side0;
    end
  end

  // Ratio divider, one quotient bit per cell.
  for (genvar i = 0; i < RATIO_W; i++) begin : g_rdiv
    a2r_div_cell #(.DW(W), .NB(RATIO_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(rv[i]), .in_div(rdiv[i]), .in_rem(rrem[i]),
      .in_bits(rbits[i]), .in_side(rside[i]),
      .out_valid(rv[i+1]), .out_div(rdiv[i+1]), .out_rem(rrem[i+1]),
      .out_bits(rbits[i+1]), .out_side(rside[i+1])
    );
  end

  // Horner chain; a zero vector gives a zero ratio.
  logic               hv    [0:4];
  logic [RATIO_W-1:0] hratio[0:4];
  val_t               hnum  [0:4];
  val_t               hden  [0:4];
  side_t              hside [0:4];

  assign hv[0]     = rv[RATIO_W];
  assign hratio[0] = rside[RATIO_W].hzero ? '0 : rbits[RATIO_W];
  assign hnum[0]   = COEF_A;
  assign hden[0]   = COEF_F;
  assign hside[0]  = rside[RATIO_W];

  a2r_horner_cell #(.KN(-COEF_B), .KD(COEF_G), .DEN_EN(1'b1)) u_h0 (
    .clk(clk), .rst(rst), .en(en), .in_valid(hv[0]), .in_ratio(hratio[0]),
    .in_num(hnum[0]), .in_den(hden[0]), .in_side(hside[0]),
    .out_valid(hv[1]), .out_ratio(hratio[1]), .out_num(hnum[1]),
    .out_den(hden[1]), .out_side(hside[1]));
  a2r_horner_cell #(.KN(-COEF_C), .KD(ONE_Q30), .DEN_EN(1'b1)) u_h1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(hv[1]), .in_ratio(hratio[1]),
    .in_num(hnum[1]), .in_den(hden[1]), .in_side(hside[1]),
    .out_valid(hv[2]), .out_ratio(hratio[2]), .out_num(hnum[2]),
    .out_den(hden[2]), .out_side(hside[2]));
  a2r_horner_cell #(.KN(-COEF_D), .KD(34'sd0), .DEN_EN(1'b0)) u_h2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(hv[2]), .in_ratio(hratio[2]),
    .in_num(hnum[2]), .in_den(hden[2]), .in_side(hside[2]),
    .out_valid(hv[3]), .out_ratio(hratio[3]), .out_num(hnum[3]),
    .out_den(hden[3]), .out_side(hside[3]));
  a2r_horner_cell #(.KN(-COEF_E), .KD(34'sd0), .DEN_EN(1'b0)) u_h3 (
    .clk(clk), .rst(rst), .en(en), .in_valid(hv[3]), .in_ratio(hratio[3]),
    .in_num(hnum[3]), .in_den(hden[3]), .in_side(hside[3]),
    .out_valid(hv[4]), .out_ratio(hratio[4]), .out_num(hnum[4]),
    .out_den(hden[4]), .out_side(hside[4]));

  // Quotient dividend: clamped numerator in Q60 plus half the denominator.
  val_t              num_pos;
  logic [QDVD_W-1:0] qdvd;
  always_comb begin
    num_pos = -hnum[4];
    if (num_pos < 0) begin
      num_pos = '0;
    end
    qdvd = {num_pos[30:0], 30'd0} + QDVD_W'(hden[4][30:1]);
  end

  logic              qv   [0:QUOT_W];
  logic [QDIV_W-1:0] qdiv [0:QUOT_W];
  logic [QDIV_W-1:0] qrem [0:QUOT_W];
  logic [QUOT_W-1:0] qbits[0:QUOT_W];
  side_t             qside[0:QUOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      qv[0] <= 1'b0;
    end else if (en) begin
      qv[0] <= hv[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qdiv[0]  <= hden[4][QDIV_W-1:0];
      qrem[0]  <= {1'b0, qdvd[QDVD_W-1:QUOT_W]};
      qbits[0] <= qdvd[QUOT_W-1:0];
      qside[0] <= hside[4];
    end
  end

  // Quotient divider, one quotient bit per cell.
  for (genvar i = 0; i < QUOT_W; i++) begin : g_qdiv
    a2r_div_cell #(.DW(QDIV_W), .NB(QUOT_W)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(qv[i]), .in_div(qdiv[i]), .in_rem(qrem[i]),
      .in_bits(qbits[i]), .in_side(qside[i]),
      .out_valid(qv[i+1]), .out_div(qdiv[i+1]), .out_rem(qrem[i+1]),
      .out_bits(qbits[i+1]), .out_side(qside[i+1])
    );
  end

  // Octant and quadrant fold, then rounding to Q13 with the sign applied.
  side_t            fs;
  val_t             fval;
  val_t             fsum;
  logic [ANGLE_W-1:0] fmag;
  always_comb begin
    fs   = qside[QUOT_W];
    fval = val_t'({1'b0, qbits[QUOT_W]});
    if (fs.swap) begin
      fval = HALF_PI_Q30 - fval;
    end
    if (fs.xneg) begin
      fval = PI_Q30 - fval;
    end
    if (fval < 0) begin
      fval = '0;
    end
    fsum = fval + val_t'(34'sd65536);
    fmag = fsum[32:17];
    if (fs.yneg) begin
      fmag = ANGLE_W'(-fmag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= qv[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= fmag;
    end
  end

  // The result never exceeds pi in magnitude.
  `A2R_ASSERT(a_angle_range, m_tvalid |-> $signed(m_tdata) <= PI_Q13 && -$signed(m_tdata) <= PI_Q13)
  // The chain takes a new item exactly when the output side can move.
  `A2R_ASSERT(a_ready_rule, s_tready == (!m_tvalid || m_tready))
  // No result comes out in the cycle after reset.
  `A2R_ASSERT(a_reset_empty, $past(rst) |-> !m_tvalid)

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the atan2 rational approximation core
// Drives vectors through the stream input with bursty timing and a stalling
// receiver. A directed table covers the axes, extremes and the zero vector,
// then random vectors follow. Every angle is checked against an in-bench
// fixed-point model of the arctangent.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int DW = ((2*CW+7)/8)*8;
  localparam int NUM_RANDOM = 1250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;

  localparam longint C_A = 64'sd54011108;
  localparam longint C_B = 64'sd332840025;
  localparam longint C_C = 64'sd158312570;
  localparam longint C_D = 64'sd1073713441;
  localparam longint C_E = 64'sd338;
  localparam longint C_F = 64'sd691988024;
  localparam longint C_G = 64'sd157951624;
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint Q30_PI = 64'sd3373259426;
  localparam longint Q30_HALF_PI = 64'sd1686629713;
  localparam int NO_ANGLE = 99999;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    int angle;  // typed-in expectation, NO_ANGLE when the model decides
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;

  logic [15:0] angle_queue[$];
  int errors = 0;
  int angles_seen = 0;
  int vectors_sent = 0;
  longint cycles = 0;

  atan2_rational_approximation_core #(.COMPONENT_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Q30 value times Q16 ratio, rounded with ties away from zero.
  function automatic longint scale_by_ratio(longint v, longint r);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m * r + 32768) >>> 16;
    return (v < 0) ? -m : m;
  endfunction

  // Expected Q13 angle of the vector (x, y).
  function automatic logic [15:0] vector_angle(logic signed [CW-1:0] x,
                                               logic signed [CW-1:0] y);
    longint ax, ay, hi, lo, r, num, den, v, mag;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    hi = (ax > ay) ? ax : ay;
    lo = (ax > ay) ? ay : ax;
    r = (hi != 0) ? ((lo << 16) + (hi >> 1)) / hi : 0;
    num = scale_by_ratio(C_A, r) - C_B;
    num = scale_by_ratio(num, r) - C_C;
    num = scale_by_ratio(num, r) - C_D;
    num = -(scale_by_ratio(num, r) - C_E);
    if (num < 0) num = 0;
    den = scale_by_ratio(scale_by_ratio(C_F, r) + C_G, r) + Q30_ONE;
    v = ((num << 30) + (den >> 1)) / den;
    if (ay > ax) v = Q30_HALF_PI - v;
    if (x < 0) v = Q30_PI - v;
    if (v < 0) v = 0;
    mag = (v + (64'd1 << 16)) >>> 17;
    if (y < 0) mag = -mag;
    return mag[15:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver stalls in a pattern of its own: quiet spells and busy spells.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each accepted angle with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      angles_seen++;
      if (angle_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected angle %0d", $signed(m_tdata)));
      end else begin
        logic [15:0] want;
        want = angle_queue.pop_front();
        if (m_tdata !== want)
          report_mismatch($sformatf("angle %0d, expected %0d",
                                    $signed(m_tdata), $signed(want)));
      end
    end
  end

  // Offer one vector and hold it until accepted; keeps valid high afterwards.
  task automatic send_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
    s_tvalid <= 1'b1;
    s_tdata <= DW'({y, x});
    do @(posedge clk); while (!s_tready);
    angle_queue.push_back(vector_angle(x, y));
    vectors_sent++;
  endtask

  task automatic pause_sender(int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  vec_row_t directed[$];

  initial begin
    int burst;
    logic signed [CW-1:0] rx, ry;
    directed = '{
      '{16'sd0, 16'sd0, 0},
      '{16'sd100, 16'sd0, 0},
      '{-16'sd100, 16'sd0, 25736},
      '{16'sd0, 16'sd100, 12868},
      '{16'sd0, -16'sd100, -12868},
      '{16'sd32767, 16'sd0, 0},
      '{-16'sd32768, 16'sd0, 25736},
      '{16'sd0, -16'sd32768, -12868},
      '{-16'sd32768, -16'sd32768, NO_ANGLE},
      '{16'sd32767, 16'sd32767, NO_ANGLE},
      '{-16'sd32768, 16'sd32767, NO_ANGLE},
      '{16'sd32767, -16'sd32768, NO_ANGLE},
      '{16'sd1, 16'sd1, NO_ANGLE},
      '{-16'sd1, -16'sd1, NO_ANGLE},
      '{16'sd1, 16'sd32767, NO_ANGLE},
      '{16'sd32767, 16'sd1, NO_ANGLE},
      '{-16'sd1, 16'sd32767, NO_ANGLE},
      '{-16'sd32768, -16'sd1, NO_ANGLE},
      '{16'sd3, -16'sd2, NO_ANGLE},
      '{-16'sd5, 16'sd7, NO_ANGLE}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; typed-in angles are checked against the model too.
    foreach (directed[i]) begin
      if (directed[i].angle != NO_ANGLE &&
          vector_angle(directed[i].x, directed[i].y) !== directed[i].angle[15:0])
        report_mismatch($sformatf("table row %0d disagrees with model", i));
      send_vector(directed[i].x, directed[i].y);
    end

    // Hold off until the pipeline has drained completely.
    s_tvalid <= 1'b0;
    while (angle_queue.size() != 0) @(posedge clk);

    // Random vectors in bursts: mostly full range, some small magnitudes.
    while (vectors_sent < NUM_RANDOM + directed.size()) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        rx = CW'($urandom);
        ry = CW'($urandom);
        if ($urandom_range(0, 4) == 0) begin
          rx = $signed(rx) >>> $urandom_range(0, 14);
          ry = $signed(ry) >>> $urandom_range(0, 14);
        end
        if ($urandom_range(0, 19) == 0) ry = rx;
        send_vector(rx, ry);
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
    end
    s_tvalid <= 1'b0;

    while (angle_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d vectors across all quadrants, axes and extremes;",
             vectors_sent);
    $display("%0d angles compared with %0d mismatches.", angles_seen, errors);
    if (errors == 0 && angle_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
